### sv/cpr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the charge pwm regulator
// no dependencies

package cpr_pkg;

  localparam int unsigned ADC_W   = 12;
  localparam int unsigned DUTY_W  = 6;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned FULL_W  = 13;
  localparam int unsigned PWM_W   = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [PWM_W-1:0]  MOTOR_PERIOD   = 7'd100;
  localparam logic [PWM_W-1:0]  MOTOR_BASE     = 7'd69;
  localparam logic [PWM_W-1:0]  CHARGE_PERIOD  = 7'd70;
  localparam logic [CNT_W-1:0]  STEP_COUNT_MAX = 5'd31;
  localparam logic [FULL_W-1:0] FULL_COUNT_MAX = 13'd8191;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_THRESH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS   = 3'd7;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_MOTOR  = 2'd1,
    MODE_CHARGE = 2'd2
  } pwm_mode_t;

  typedef struct packed {
    logic [ADC_W-1:0]  current_low_limit;
    logic [ADC_W-1:0]  current_high_limit;
    logic [ADC_W-1:0]  battery_max;
    logic [ADC_W-1:0]  full_threshold;
    logic [ADC_W-1:0]  full_ticks;
    logic [DUTY_W-1:0] duty_max;
    logic [DUTY_W-1:0] duty_min;
    logic [STEP_W-1:0] step_ticks;
  } cfg_t;

  typedef struct packed {
    logic               charger_present;
    logic [ADC_W-1:0]   charge_adc;
    logic [ADC_W-1:0]   battery_adc;
    logic [LEVEL_W-1:0] motor_level;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] charge_duty;
    logic [CNT_W-1:0]  raise_count;
    logic [CNT_W-1:0]  lower_count;
    logic [FULL_W-1:0] full_count;
    logic              charging;
    logic              full;
  } reg_state_t;

  typedef struct packed {
    pwm_mode_t        pwm_mode;
    logic [PWM_W-1:0] pwm_period;
    logic [PWM_W-1:0] pwm_duty;
    logic             charging;
    logic             charge_full;
  } result_t;

endpackage

### sv/charge_pwm_regulator_core.sv
`timescale 1ns / 1ps
// top level of the charge / motor pwm regulator: config registers, pipeline and state
// depends on cpr_pkg and cpr_regulate

// usage
//   one input word per control tick on in_valid / in_ready: charger presence,
//   charge current and battery readings, motor level
//   one result word per input word on out_valid / out_ready: pwm mode, period,
//   duty and the charging / full flags after that tick
//   a word is captured in the input register, then the regulation logic
//   updates the state and loads the result register, which raises out_valid;
//   one word per cycle sustained while the receiver keeps out_ready high,
//   bounded only by the single state update in the result stage
//   when the receiver stalls, the result register holds, the input register
//   fills, and in_ready drops only when both are full; no word is dropped
//   config writes on cfg_write / cfg_index / cfg_data take effect at once and
//   are meant for idle periods
//   synchronous reset clears the pipeline, all state, and loads the register
//   defaults (limits 70 / 80, battery max 1555, full 1545 over 2500 ticks,
//   duty 10..35, a step after over 10 ticks)

module charge_pwm_regulator_core import cpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // config port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  charger_present,
  input  logic [ADC_W-1:0]      charge_adc,
  input  logic [ADC_W-1:0]      battery_adc,
  input  logic [LEVEL_W-1:0]    motor_level,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            pwm_mode,
  output logic [PWM_W-1:0]      pwm_period,
  output logic [PWM_W-1:0]      pwm_duty,
  output logic                  charging,
  output logic                  charge_full
);

  cfg_t       cfg;
  reg_state_t st;
  reg_state_t st_next;
  in_word_t   s1_word;
  logic       s1_valid;
  result_t    res;
  result_t    res_next;
  logic       s1_advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_low_limit  <= 12'd70;
      cfg.current_high_limit <= 12'd80;
      cfg.battery_max        <= 12'd1555;
      cfg.full_threshold     <= 12'd1545;
      cfg.full_ticks         <= 12'd2500;
      cfg.duty_max           <= 6'd35;
      cfg.duty_min           <= 6'd10;
      cfg.step_ticks         <= 4'd10;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CURRENT_LOW:  cfg.current_low_limit  <= cfg_data;
        REG_CURRENT_HIGH: cfg.current_high_limit <= cfg_data;
        REG_BATTERY_MAX:  cfg.battery_max        <= cfg_data;
        REG_FULL_THRESH:  cfg.full_threshold     <= cfg_data;
        REG_FULL_TICKS:   cfg.full_ticks         <= cfg_data;
        REG_DUTY_MAX:     cfg.duty_max           <= cfg_data[DUTY_W-1:0];
        REG_DUTY_MIN:     cfg.duty_min           <= cfg_data[DUTY_W-1:0];
        REG_STEP_TICKS:   cfg.step_ticks         <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // the input stage moves on when the result register is empty or being drained
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word.charger_present <= charger_present;
      s1_word.charge_adc      <= charge_adc;
      s1_word.battery_adc     <= battery_adc;
      s1_word.motor_level     <= motor_level;
    end
  end

  cpr_regulate u_regulate (
    .cfg     (cfg),
    .word    (s1_word),
    .st      (st),
    .st_next (st_next),
    .res     (res_next)
  );

  // state commits exactly when the word in the input stage becomes a result
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_valid && s1_advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      res <= res_next;
    end
  end

  assign pwm_mode    = res.pwm_mode;
  assign pwm_period  = res.pwm_period;
  assign pwm_duty    = res.pwm_duty;
  assign charging    = res.charging;
  assign charge_full = res.charge_full;

`ifndef SYNTHESIS
  // duty is cleared on unplug and only regulated while charging
  a_duty_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !st.charging |-> st.charge_duty == '0)
    else $error("charge duty nonzero while not charging");

  // full can only be reported together with charging
  a_full_needs_charging: assert property (@(posedge clk) disable iff (rst)
    out_valid && charge_full |-> charging)
    else $error("full flag without charging flag");

  // back pressure only when both stages hold a word
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with a free stage");

  // a stalled word in the input stage must not move the state
  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(st))
    else $error("state changed during output stall");
`endif

endmodule

### sv/cpr_regulate.sv
`timescale 1ns / 1ps
// one tick of regulation and charger bookkeeping, purely combinational
// depends on cpr_pkg

module cpr_regulate import cpr_pkg::*; (
  input  cfg_t       cfg,
  input  in_word_t   word,
  input  reg_state_t st,
  output reg_state_t st_next,
  output result_t    res
);

  logic              motor_on;
  logic              regulate;
  logic              raise_cond;
  logic              lower_cond;
  logic [CNT_W-1:0]  raise_bump;
  logic [CNT_W-1:0]  lower_bump;
  logic              raise_step;
  logic              lower_step;
  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic [CNT_W-1:0]  raise_n;
  logic [CNT_W-1:0]  lower_n;
  logic              above_thresh;
  logic [FULL_W-1:0] full_bump;
  logic              full_hit;

  always_comb begin
    motor_on = word.motor_level != '0;
    regulate = !motor_on && st.charging && !st.full;

    // raise path
    raise_cond = (word.charge_adc < cfg.current_low_limit) &&
                 (word.battery_adc <= cfg.battery_max);
    raise_bump = (st.raise_count < STEP_COUNT_MAX) ? st.raise_count + 1'b1 : STEP_COUNT_MAX;
    raise_step = raise_cond && (raise_bump > {1'b0, cfg.step_ticks}) &&
                 (st.charge_duty < cfg.duty_max);
    raise_n    = (!raise_cond || raise_step) ? '0 : raise_bump;
    duty_a     = raise_step ? st.charge_duty + 1'b1 : st.charge_duty;

    // lower path sees the duty after a possible raise
    lower_cond = (word.charge_adc > cfg.current_high_limit) ||
                 (word.battery_adc > cfg.battery_max);
    lower_bump = (st.lower_count < STEP_COUNT_MAX) ? st.lower_count + 1'b1 : STEP_COUNT_MAX;
    lower_step = lower_cond && (lower_bump > {1'b0, cfg.step_ticks}) &&
                 (duty_a > cfg.duty_min);
    lower_n    = (!lower_cond || lower_step) ? '0 : lower_bump;
    duty_b     = lower_step ? duty_a - 1'b1 : duty_a;

    // full detection
    above_thresh = word.battery_adc > cfg.full_threshold;
    full_bump    = (st.full_count < FULL_COUNT_MAX) ? st.full_count + 1'b1 : FULL_COUNT_MAX;
    full_hit     = above_thresh && (full_bump > {1'b0, cfg.full_ticks});

    st_next = st;
    if (regulate) begin
      st_next.raise_count = raise_n;
      st_next.lower_count = lower_n;
      st_next.charge_duty = duty_b;
    end

    if (word.charger_present) begin
      st_next.charging   = 1'b1;
      st_next.full_count = (!above_thresh || full_hit) ? '0 : full_bump;
      st_next.full       = st.full || full_hit;
    end else begin
      st_next.charging    = 1'b0;
      st_next.full        = 1'b0;
      st_next.full_count  = '0;
      st_next.charge_duty = '0;
    end

    if (motor_on) begin
      res.pwm_mode   = MODE_MOTOR;
      res.pwm_period = MOTOR_PERIOD;
      res.pwm_duty   = MOTOR_BASE + PWM_W'(word.motor_level);
    end else if (regulate) begin
      res.pwm_mode   = MODE_CHARGE;
      res.pwm_period = CHARGE_PERIOD;
      res.pwm_duty   = PWM_W'(duty_b);
    end else begin
      res.pwm_mode   = MODE_OFF;
      res.pwm_period = '0;
      res.pwm_duty   = '0;
    end
    res.charging    = st_next.charging;
    res.charge_full = st_next.full;
  end

endmodule
